>>> rtl/pvc_pkg.sv
package pvc_pkg;

	localparam int GAIN_W  = 24;
	localparam int PULSE_W = 16;
	localparam int VENT_W  = 15;
	localparam int FAN_W   = 7;
	localparam int TEMP_W  = 8;
	localparam int SUM_W   = 32;
	localparam int ERR_W   = 9;

	localparam logic [VENT_W-1:0] VENT_FULL = 15'd25600;
	localparam logic signed [SUM_W-1:0] SUM_LIMIT = 32'sh7FFF_FFFF;

	// 180 degrees in unsigned Q8.8; split into 2^10 * 45 for the servo divide
	localparam logic [15:0] ANGLE_SPAN_Q8 = 16'd46080;
	localparam int SERVO_SHIFT = 10;
	localparam int SERVO_RK    = 28;
	localparam logic [22:0] SERVO_RM = 23'd5965233;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_PROP_GAIN     = 3'd0,
		REG_INTEG_GAIN    = 3'd1,
		REG_DERIV_GAIN    = 3'd2,
		REG_PULSE_AT_ZERO = 3'd3,
		REG_PULSE_AT_FULL = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [PULSE_W-1:0] pulse_at_zero;
		logic [PULSE_W-1:0] pulse_at_full;
	} cfg_t;

endpackage

>>> rtl/pid_vent_controller.sv
// PID vent controller. Each transaction on the slave stream is one control update
// (room_temp in tdata[7:0], target_temp in tdata[15:8]) and yields exactly one
// transaction on the master stream with the clamped vent level in Q7.8, the fan
// percent and the servo pulse width. The block runs a six-stage pipeline and
// accepts one update per clock while any stage can advance; a result moves
// through the valid registers v_s1 to v_s6 and is offered from v_s6. The
// pipeline keeps accepting while a result waits as long as any stage is empty.
// The integral and last-error state are updated in the accept cycle, so
// updates may follow back to back. Gains and servo end points sit in an APB
// register file and should be written while no update is in flight.
module pid_vent_controller
	import pvc_pkg::*;
#(
	parameter int UPDATE_PERIOD = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,  // room_temp[7:0], target_temp[15:8]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,  // vent_level[14:0], fan_percent[21:15],
	                                        // servo_pulse_us[37:22], zero pad[39:38]
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int  DTW  = $clog2(UPDATE_PERIOD + 1) + 1;
	localparam int  PW   = 34;
	localparam int  IW   = 58;
	localparam int  DW   = 35;
	localparam int  SW   = IW + DTW + 1;
	localparam longint FULL = 64'd6553600 * UPDATE_PERIOD;
	localparam int  XW   = $clog2(FULL);
	localparam int  QW   = XW - 8;
	localparam int  RK   = QW + $clog2(UPDATE_PERIOD) + 1;
	localparam longint RM = ((64'd1 << RK) + UPDATE_PERIOD - 1) / UPDATE_PERIOD;
	localparam int  RW   = RK + 1;
	localparam int  MW   = QW + RW;
	localparam int  NW   = 32 - SERVO_SHIFT;
	localparam int  NMW  = NW + 23;

	cfg_t cfg;

	pvc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic accept;

	assign en6      = !v_s6 || m_tready;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [ERR_W-1:0] last_error_q;
	logic signed [ERR_W-1:0] err_c;
	logic signed [33:0]      sum_raw;
	logic signed [SUM_W-1:0] sum_c;
	logic signed [9:0]       diff_c;

	always_comb begin
		err_c   = signed'({1'b0, s_tdata[7:0]}) - signed'({1'b0, s_tdata[15:8]});
		sum_raw = 34'(error_sum_q) + 34'(err_c) * 34'(signed'(DTW'(UPDATE_PERIOD)));
		if (sum_raw > 34'(SUM_LIMIT)) begin
			sum_c = SUM_LIMIT;
		end else if (sum_raw < -34'(SUM_LIMIT)) begin
			sum_c = -SUM_LIMIT;
		end else begin
			sum_c = sum_raw[SUM_W-1:0];
		end
		diff_c = 10'(err_c) - 10'(last_error_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (accept) begin
			error_sum_q  <= sum_c;
			last_error_q <= err_c;
		end
	end

	logic signed [ERR_W-1:0] err_s1;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [9:0]       diff_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			err_s1  <= err_c;
			sum_s1  <= sum_c;
			diff_s1 <= diff_c;
		end
	end

	logic signed [PW-1:0] p_s2;
	logic signed [IW-1:0] i_s2;
	logic signed [DW-1:0] d_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= PW'(signed'({1'b0, cfg.prop_gain})) * PW'(err_s1);
			i_s2 <= IW'(signed'({1'b0, cfg.integ_gain})) * IW'(sum_s1);
			d_s2 <= DW'(signed'({1'b0, cfg.deriv_gain})) * DW'(diff_s1);
		end
	end

	logic signed [SW-1:0] s_c;
	logic                 zero_s3, full_s3;
	logic [QW-1:0]        x_s3;

	assign s_c = (SW'(p_s2) + SW'(i_s2)) * SW'(signed'(DTW'(UPDATE_PERIOD))) + SW'(d_s2);

	always_ff @(posedge clk) begin
		if (en3) begin
			zero_s3 <= s_c <= 0;
			full_s3 <= s_c >= SW'(FULL);
			x_s3    <= s_c[XW-1:8];
		end
	end

	logic [MW-1:0]     q_c;
	logic [VENT_W-1:0] vent_s4;

	assign q_c = MW'(x_s3) * MW'(RM);

	always_ff @(posedge clk) begin
		if (en4) begin
			if (zero_s3) begin
				vent_s4 <= '0;
			end else if (full_s3) begin
				vent_s4 <= VENT_FULL;
			end else begin
				vent_s4 <= q_c[RK+VENT_W-1:RK];
			end
		end
	end

	logic signed [16:0] span_c;
	logic [31:0]        base_c;
	logic signed [33:0] num_c;
	logic [VENT_W-1:0]  vent_s5;
	logic [FAN_W-1:0]   fan_s5;
	logic [31:0]        num_s5;

	always_comb begin
		span_c = signed'({1'b0, cfg.pulse_at_full}) - signed'({1'b0, cfg.pulse_at_zero});
		base_c = 32'(cfg.pulse_at_zero) * 32'(ANGLE_SPAN_Q8);
		num_c  = signed'({2'b00, base_c})
			+ 34'(signed'({1'b0, vent_s4})) * 34'(span_c);
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			vent_s5 <= vent_s4;
			fan_s5  <= FAN_W'((16'(vent_s4) + 16'd128) >> 8);
			num_s5  <= num_c[33] ? 32'd0 : num_c[31:0];
		end
	end

	logic [NMW-1:0]     servo_c;
	logic [VENT_W-1:0]  vent_s6;
	logic [FAN_W-1:0]   fan_s6;
	logic [PULSE_W-1:0] servo_s6;

	assign servo_c = NMW'(num_s5[31:SERVO_SHIFT]) * NMW'(SERVO_RM);

	always_ff @(posedge clk) begin
		if (en6) begin
			vent_s6  <= vent_s5;
			fan_s6   <= fan_s5;
			servo_s6 <= servo_c[SERVO_RK+PULSE_W-1:SERVO_RK];
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {2'b00, servo_s6, fan_s6, vent_s6};

`ifndef NO_ASSERTIONS
	a_sum_sat: assert property (@(posedge clk) disable iff (!arst_n)
		error_sum_q != -SUM_LIMIT - 32'sd1)
		else $error("integral left its saturation range");

	a_fan_round: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (vent_s6 <= VENT_FULL)
			&& (fan_s6 == FAN_W'((16'(vent_s6) + 16'd128) >> 8)))
		else $error("fan percent does not match vent level");

	a_servo_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((servo_s6 >= cfg.pulse_at_zero && servo_s6 <= cfg.pulse_at_full)
			|| (servo_s6 <= cfg.pulse_at_zero && servo_s6 >= cfg.pulse_at_full)))
		else $error("servo pulse outside the configured end points");
`endif

endmodule

>>> rtl/pvc_regs.sv
module pvc_regs
	import pvc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain     <= 24'd655360;
			cfg_q.integ_gain    <= 24'd6554;
			cfg_q.deriv_gain    <= 24'd327680;
			cfg_q.pulse_at_zero <= 16'd2000;
			cfg_q.pulse_at_full <= 16'd1000;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROP_GAIN:     cfg_q.prop_gain     <= pwdata[GAIN_W-1:0];
				REG_INTEG_GAIN:    cfg_q.integ_gain    <= pwdata[GAIN_W-1:0];
				REG_DERIV_GAIN:    cfg_q.deriv_gain    <= pwdata[GAIN_W-1:0];
				REG_PULSE_AT_ZERO: cfg_q.pulse_at_zero <= pwdata[PULSE_W-1:0];
				REG_PULSE_AT_FULL: cfg_q.pulse_at_full <= pwdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_PROP_GAIN:     prdata = CFG_DATA_W'(cfg_q.prop_gain);
			REG_INTEG_GAIN:    prdata = CFG_DATA_W'(cfg_q.integ_gain);
			REG_DERIV_GAIN:    prdata = CFG_DATA_W'(cfg_q.deriv_gain);
			REG_PULSE_AT_ZERO: prdata = CFG_DATA_W'(cfg_q.pulse_at_zero);
			REG_PULSE_AT_FULL: prdata = CFG_DATA_W'(cfg_q.pulse_at_full);
			default:           prdata = '0;
		endcase
	end

endmodule

>>> verif/tb.sv
module tb;
	import pvc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DT = 5;
	localparam int QUIET_LIMIT = 3000;
	localparam int FIRST_SPARE_REG = 5;
	localparam int LAST_SPARE_REG = 7;
	localparam int FLUSH_CYCLES = 12;

	typedef struct packed {
		logic [TEMP_W-1:0] target;
		logic [TEMP_W-1:0] room;
	} reading_t;

	typedef struct packed {
		logic [PULSE_W-1:0] servo;
		logic [FAN_W-1:0]   fan;
		logic [VENT_W-1:0]  vent;
	} vent_cmd_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [15:0]           s_tdata = '0;   // room_temp[7:0], target_temp[15:8]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [39:0]           m_tdata;        // vent_level[14:0], fan_percent[21:15],
	                                       // servo_pulse_us[37:22], zero pad[39:38]
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	reading_t          update_q[$];
	vent_cmd_t         cmd_q[$];
	cfg_t              vent_cfg;
	logic signed [SUM_W-1:0] integ_acc = '0;
	logic signed [ERR_W-1:0] prev_err = '0;
	int                err_count = 0;
	int                quiet_cycles = 0;
	int                idle_pct = 20;
	bit                s_fire = 1'b0;

	pid_vent_controller #(.UPDATE_PERIOD(DT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic vent_cmd_t control_update(reading_t rd);
		longint err;
		longint sum;
		longint s;
		longint vent;
		longint num;
		vent_cmd_t c;
		err = longint'(rd.room) - longint'(rd.target);
		sum = longint'(integ_acc) + err * DT;
		if (sum > longint'(SUM_LIMIT))
			sum = longint'(SUM_LIMIT);
		else if (sum < -longint'(SUM_LIMIT))
			sum = -longint'(SUM_LIMIT);
		s = (longint'(vent_cfg.prop_gain) * err + longint'(vent_cfg.integ_gain) * sum) * DT
			+ longint'(vent_cfg.deriv_gain) * (err - longint'(prev_err));
		integ_acc = sum[SUM_W-1:0];
		prev_err = err[ERR_W-1:0];
		if (s <= 0)
			vent = 0;
		else if (s >= longint'(100) * 65536 * DT)
			vent = longint'(VENT_FULL);
		else
			vent = s / (256 * DT);
		num = longint'(vent_cfg.pulse_at_zero) * longint'(ANGLE_SPAN_Q8)
			+ vent * (longint'(vent_cfg.pulse_at_full) - longint'(vent_cfg.pulse_at_zero));
		if (num < 0)
			num = 0;
		num = num / longint'(ANGLE_SPAN_Q8);
		c.vent = vent[VENT_W-1:0];
		vent = (vent + 128) >> 8;
		c.fan = vent[FAN_W-1:0];
		c.servo = num[PULSE_W-1:0];
		return c;
	endfunction

	// driver: hold an offered transaction until taken
	always @(negedge clk) begin
		if (!(s_tvalid && !s_fire)) begin
			if (update_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= update_q[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		s_fire = arst_n && s_tvalid && s_tready;
		if (s_fire) begin
			cmd_q.push_back(control_update(update_q[0]));
			void'(update_q.pop_front());
		end
	end

	always @(posedge clk) begin
		vent_cmd_t got;
		vent_cmd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[37:0];
			if (cmd_q.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got %h", $time, m_tdata);
				err_count++;
			end else begin
				want = cmd_q.pop_front();
				if (got.vent != want.vent) begin
					$display("%0t: vent_level expected %0d got %0d", $time, want.vent, got.vent);
					err_count++;
				end
				if (got.fan != want.fan) begin
					$display("%0t: fan_percent expected %0d got %0d", $time, want.fan, got.fan);
					err_count++;
				end
				if (got.servo != want.servo) begin
					$display("%0t: servo_pulse_us expected %0d got %0d", $time,
						want.servo, got.servo);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (psel && penable && pwrite && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic reg_write(input int idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(idx * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_PROP_GAIN:     vent_cfg.prop_gain = val[GAIN_W-1:0];
			REG_INTEG_GAIN:    vent_cfg.integ_gain = val[GAIN_W-1:0];
			REG_DERIV_GAIN:    vent_cfg.deriv_gain = val[GAIN_W-1:0];
			REG_PULSE_AT_ZERO: vent_cfg.pulse_at_zero = val[PULSE_W-1:0];
			REG_PULSE_AT_FULL: vent_cfg.pulse_at_full = val[PULSE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_regs(input logic [31:0] kp, input logic [31:0] ki,
			input logic [31:0] kd, input logic [31:0] pz, input logic [31:0] pf);
		reg_write(REG_PROP_GAIN, kp);
		reg_write(REG_INTEG_GAIN, ki);
		reg_write(REG_DERIV_GAIN, kd);
		reg_write(REG_PULSE_AT_ZERO, pz);
		reg_write(REG_PULSE_AT_FULL, pf);
		reg_write($urandom_range(FIRST_SPARE_REG, LAST_SPARE_REG), $urandom);
	endtask

	task automatic offer(input int room, input int target);
		reading_t r;
		r.room = TEMP_W'(room);
		r.target = TEMP_W'(target);
		update_q.push_back(r);
	endtask

	task automatic queue_updates(input int n);
		int target;
		int room;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80) begin
				target = $urandom_range(55, 90);
				room = target + $urandom_range(0, 24) - 12;
			end else begin
				target = $urandom_range(255);
				room = $urandom_range(255);
			end
			offer(room, target);
		end
	endtask

	task automatic drain;
		while (update_q.size() != 0 || cmd_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [31:0] kp;
		logic [31:0] ki;
		logic [31:0] kd;
		vent_cfg.prop_gain = 24'd655360;
		vent_cfg.integ_gain = 24'd6554;
		vent_cfg.deriv_gain = 24'd327680;
		vent_cfg.pulse_at_zero = 16'd2000;
		vent_cfg.pulse_at_full = 16'd1000;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		offer(0, 0);
		offer(255, 255);
		offer(255, 0);
		offer(0, 255);
		offer(72, 72);
		offer(73, 72);
		offer(74, 72);
		offer(71, 72);
		offer(72, 71);
		offer(80, 72);
		offer(170, 85);
		offer(85, 170);
		offer(128, 127);
		offer(127, 128);
		offer(60, 70);
		offer(200, 10);
		offer(10, 200);
		drain();

		load_regs(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 32'hFFFF_0000, 32'h0000_FFFF);
		queue_updates(40);
		drain();

		load_regs(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h0000_FFFF, 32'h0000_0000);
		queue_updates(40);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			kp = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 32'h0014_0000);
			ki = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 800);
			kd = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 32'h0014_0000);
			kp[31:24] = 8'($urandom);
			ki[31:24] = 8'($urandom);
			kd[31:24] = 8'($urandom);
			load_regs(kp, ki, kd, $urandom, $urandom);
			idle_pct = (ph == 2) ? 0 : 20;
			queue_updates((ph == 2) ? 250 : 100);
			drain();
		end

		idle_pct = 20;
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> pid_vent_controller.f
rtl/pvc_pkg.sv
rtl/pvc_regs.sv
rtl/pid_vent_controller.sv
verif/tb.sv
